[hw/rtl/source_line_classifier_assert.svh]
`ifndef SOURCE_LINE_CLASSIFIER_ASSERT_SVH
`define SOURCE_LINE_CLASSIFIER_ASSERT_SVH

// Checks that a condition in the same cycle implies a consequence.
`define SLC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source_line_classifier: same-cycle check failed");

// Checks that a condition implies a consequence in the next cycle.
`define SLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source_line_classifier: next-cycle check failed");

`endif

[hw/rtl/slc_pkg.sv]
package slc_pkg;

    localparam int COUNT_BITS = 32;
    // Width that holds both a count and a 32-bit result for the clamp compare.
    localparam int EXT_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    // Width of the code count difference, with room for a negative result.
    localparam int DIFF_BITS = COUNT_BITS + 2;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [7:0] byte_t;
    typedef logic [31:0] result_t;

    localparam byte_t BYTE_NL    = 8'd10;
    localparam byte_t BYTE_CR    = 8'd13;
    localparam byte_t BYTE_TAB   = 8'd9;
    localparam byte_t BYTE_SPACE = 8'd32;
    localparam byte_t BYTE_SLASH = 8'd47;
    localparam byte_t BYTE_STAR  = 8'd42;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    function automatic count_t sat_inc(input count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

    function automatic result_t clamp_out(input count_t v);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v);
        return (ext > EXT_BITS'(32'hFFFF_FFFF)) ? '1 : ext[31:0];
    endfunction

    function automatic logic is_white(input byte_t b);
        return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_CR) || (b == BYTE_NL);
    endfunction

endpackage

[hw/rtl/source_line_classifier.sv]
// Line classifier for one source file at a time: feed the file's bytes with
// kind 0 and then one item with kind 1 to mark end of file. One item is
// accepted per clock cycle; the byte path updates the previous byte, the
// comment and code flags and at most one saturating increment of each line
// counter in a single cycle. The end-of-file result passes a count snapshot
// stage and then the result register before it is offered, while the bytes
// of the next file are already being taken. The input stalls only when both
// the snapshot stage and the result register hold work that the output side
// has not taken.
module source_line_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                kind,
    input  logic [7:0]          data_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [31:0]         line_count,
    output logic [31:0]         blank_count,
    output logic [31:0]         comment_count,
    output logic [31:0]         code_count
);

    slc_pkg::byte_t  prev_reg, prev_next;
    logic            line_reg, line_next;
    logic            blk_reg, blk_next;
    logic            code_reg, code_next;
    slc_pkg::count_t lines_reg, lines_next;
    slc_pkg::count_t blank_reg, blank_next;
    slc_pkg::count_t comm_reg, comm_next;

    logic            s1_valid_reg, s1_valid_next;
    slc_pkg::count_t fin_lines_reg, fin_lines_next;
    slc_pkg::count_t fin_blank_reg, fin_blank_next;
    slc_pkg::count_t fin_comm_reg, fin_comm_next;

    logic             result_valid_reg, result_valid_next;
    slc_pkg::result_t line_count_reg, blank_count_reg, comment_count_reg, code_count_reg;
    logic [slc_pkg::DIFF_BITS-1:0] code_diff;

    logic item_accept;
    logic is_byte;
    logic is_eof;
    logic s1_advance;

    // Counters after closing the current line with the given flags.
    logic            close_comment;
    logic            close_code;
    slc_pkg::count_t lines_closed, blank_closed, comm_closed;

    logic line_v, blk_v, code_v, closing;

    assign s1_advance  = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready  = !s1_valid_reg || s1_advance;
    assign item_accept = item_valid && item_ready;
    assign is_byte     = item_accept && (kind == slc_pkg::KIND_BYTE);
    assign is_eof      = item_accept && (kind == slc_pkg::KIND_EOF);

    always_comb
    begin
        line_v  = line_reg |
                  ((prev_reg == slc_pkg::BYTE_SLASH) && (data_byte == slc_pkg::BYTE_SLASH) &&
                   !blk_reg);
        blk_v   = blk_reg |
                  ((prev_reg == slc_pkg::BYTE_SLASH) && (data_byte == slc_pkg::BYTE_STAR) &&
                   !line_v);
        closing = (prev_reg == slc_pkg::BYTE_STAR) && (data_byte == slc_pkg::BYTE_SLASH) &&
                  blk_v;
        code_v  = code_reg | (!line_v && !blk_v && !slc_pkg::is_white(data_byte));

        // At end of file the stored flags close the final line; on a newline
        // the flags as updated by this byte do.
        if (is_eof)
        begin
            close_comment = line_reg || blk_reg;
            close_code    = code_reg;
        end
        else
        begin
            close_comment = line_v || blk_v;
            close_code    = code_v;
        end

        lines_closed = slc_pkg::sat_inc(lines_reg);
        comm_closed  = close_comment ? slc_pkg::sat_inc(comm_reg) : comm_reg;
        blank_closed = (!close_comment && !close_code) ? slc_pkg::sat_inc(blank_reg)
                                                       : blank_reg;
    end

    always_comb
    begin
        prev_next      = prev_reg;
        line_next      = line_reg;
        blk_next       = blk_reg;
        code_next      = code_reg;
        lines_next     = lines_reg;
        blank_next     = blank_reg;
        comm_next      = comm_reg;
        fin_lines_next = fin_lines_reg;
        fin_blank_next = fin_blank_reg;
        fin_comm_next  = fin_comm_reg;

        if (is_eof)
        begin
            if (prev_reg != slc_pkg::BYTE_NL)
            begin
                fin_lines_next = lines_closed;
                fin_blank_next = blank_closed;
                fin_comm_next  = comm_closed;
            end
            else
            begin
                fin_lines_next = lines_reg;
                fin_blank_next = blank_reg;
                fin_comm_next  = comm_reg;
            end
            prev_next  = slc_pkg::BYTE_NL;
            line_next  = 1'b0;
            blk_next   = 1'b0;
            code_next  = 1'b0;
            lines_next = '0;
            blank_next = '0;
            comm_next  = '0;
        end
        else if (is_byte)
        begin
            prev_next = data_byte;
            if (closing)
            begin
                // The closing slash ends the block comment and is not code.
                line_next = line_v;
                blk_next  = 1'b0;
            end
            else if (data_byte == slc_pkg::BYTE_NL)
            begin
                lines_next = lines_closed;
                blank_next = blank_closed;
                comm_next  = comm_closed;
                line_next  = 1'b0;
                blk_next   = blk_v;
                code_next  = 1'b0;
            end
            else
            begin
                line_next = line_v;
                blk_next  = blk_v;
                code_next = code_v;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (is_eof)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (s1_advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // A negative difference means saturation pushed blank plus comment past the total.
    assign code_diff = {2'b00, fin_lines_reg} - {2'b00, fin_blank_reg} - {2'b00, fin_comm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= slc_pkg::BYTE_NL;
            line_reg         <= 1'b0;
            blk_reg          <= 1'b0;
            code_reg         <= 1'b0;
            lines_reg        <= '0;
            blank_reg        <= '0;
            comm_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg         <= prev_next;
            line_reg         <= line_next;
            blk_reg          <= blk_next;
            code_reg         <= code_next;
            lines_reg        <= lines_next;
            blank_reg        <= blank_next;
            comm_reg         <= comm_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_lines_reg <= fin_lines_next;
        fin_blank_reg <= fin_blank_next;
        fin_comm_reg  <= fin_comm_next;
        if (s1_advance)
        begin
            line_count_reg    <= slc_pkg::clamp_out(fin_lines_reg);
            blank_count_reg   <= slc_pkg::clamp_out(fin_blank_reg);
            comment_count_reg <= slc_pkg::clamp_out(fin_comm_reg);
            code_count_reg    <= code_diff[slc_pkg::DIFF_BITS-1] ? '0
                               : slc_pkg::clamp_out(code_diff[slc_pkg::COUNT_BITS-1:0]);
        end
    end

    assign result_valid  = result_valid_reg;
    assign line_count    = line_count_reg;
    assign blank_count   = blank_count_reg;
    assign comment_count = comment_count_reg;
    assign code_count    = code_count_reg;

`include "source_line_classifier_assert.svh"

    `SLC_ASSERT_SAME(a_stall_when_full,
        s1_valid_reg && result_valid_reg && !result_ready, !item_ready)
    `SLC_ASSERT_NEXT(a_eof_clears_state, is_eof,
        prev_reg == slc_pkg::BYTE_NL && !line_reg && !blk_reg && !code_reg &&
        lines_reg == '0 && s1_valid_reg)
    `SLC_ASSERT_SAME(a_counts_bounded, result_valid_reg,
        line_count_reg >= blank_count_reg && line_count_reg >= comment_count_reg)

endmodule
